>>> rtl/core/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and codes for the sorted table block.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef logic [VALUE_W-1:0] value_t;

  // shift request broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } sti_ctl_t;

  // per-cell state flags seen by the neighbors and the chain
  typedef struct packed {
    logic valid;
    logic lt;
    logic eq;
  } sti_flag_t;

  // summary of the whole chain
  typedef struct packed {
    logic found;
    logic full;
  } sti_stat_t;

endpackage

>>> rtl/core/sti_cell.sv
// ----------------------------------------------------------------------------
// sti_cell
// One table slot: compares against the broadcast value and shifts left/right.
// ----------------------------------------------------------------------------
module sti_cell (
  input  logic               clk,
  input  logic               rst,
  input  sti_pkg::sti_ctl_t  ctl,
  input  sti_pkg::value_t    value,
  input  sti_pkg::sti_flag_t left_flag,
  input  sti_pkg::value_t    left_data,
  input  sti_pkg::sti_flag_t right_flag,
  input  sti_pkg::value_t    right_data,
  output sti_pkg::sti_flag_t flag,
  output sti_pkg::value_t    data
);

  logic valid;
  logic valid_next;
  sti_pkg::value_t data_next;

  always_comb begin
    flag.valid = valid;
    flag.lt    = valid && ($signed(data) < $signed(value));
    flag.eq    = valid && (data == value);
  end

  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (ctl.ins && !flag.lt) begin
      if (left_flag.lt) begin
        valid_next = 1'b1;
        data_next  = value;
      end else begin
        valid_next = left_flag.valid;
        data_next  = left_data;
      end
    end else if (ctl.rem && !flag.lt) begin
      valid_next = right_flag.valid;
      data_next  = right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> rtl/core/sti_chain.sv
// ----------------------------------------------------------------------------
// sti_chain
// Row of CAPACITY cells kept in ascending signed order, slot 0 lowest.
// ----------------------------------------------------------------------------
module sti_chain #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  sti_pkg::sti_ctl_t ctl,
  input  sti_pkg::value_t   value,
  output sti_pkg::sti_stat_t stat
);

  sti_pkg::sti_flag_t flags [CAPACITY];
  sti_pkg::value_t    datas [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sti_pkg::sti_flag_t lf;
    sti_pkg::value_t    ld;
    sti_pkg::sti_flag_t rf;
    sti_pkg::value_t    rd;

    if (i == 0) begin : g_head
      // head sees a virtual smaller neighbor so an insert not above the smallest stored value lands here
      assign lf = '{valid: 1'b1, lt: 1'b1, eq: 1'b0};
      assign ld = '0;
    end else begin : g_left
      assign lf = flags[i-1];
      assign ld = datas[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rf = '0;
      assign rd = '0;
    end else begin : g_right
      assign rf = flags[i+1];
      assign rd = datas[i+1];
    end

    sti_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .value      (value),
      .left_flag  (lf),
      .left_data  (ld),
      .right_flag (rf),
      .right_data (rd),
      .flag       (flags[i]),
      .data       (datas[i])
    );

    assign eq_vec[i] = flags[i].eq;
  end

  assign stat.found = |eq_vec;
  assign stat.full  = flags[CAPACITY-1].valid;

endmodule

>>> rtl/core/sorted_table_insert_remove_find_top.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_find_top
// Sorted table of signed words with insert, remove and find.
//
//   channel | dir | tdata              | tuser
//   s_*     | in  | [31:0] value       | [1:0] cmd
//   m_*     | out | [4:0] entry_count  | [1:0] status
//
// One word per cycle while s_tready is high: all cells compare against the
// broadcast value and shift in the same cycle that the word is accepted.
// Result appears in the output register in the cycle after acceptance.
// s_tready drops only while a result is held and m_tready is low.
// Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_find_top #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0] s_tuser,    // [1:0] cmd
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [4:0] entry_count, [7:5] zero
  output logic [1:0] m_tuser     // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  sti_pkg::sti_ctl_t  ctl;
  sti_pkg::sti_stat_t stat;
  logic [sti_pkg::STATUS_W-1:0] status_next;
  logic [sti_pkg::COUNT_W-1:0]  entry_count;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    ctl.ins     = 1'b0;
    ctl.rem     = 1'b0;
    status_next = sti_pkg::ST_MISSING;
    case (s_tuser)
      sti_pkg::CMD_INSERT: begin
        if (stat.full) begin
          status_next = sti_pkg::ST_FULL;
        end else begin
          status_next = sti_pkg::ST_OK;
          ctl.ins     = accept;
        end
      end
      sti_pkg::CMD_REMOVE: begin
        if (stat.found) begin
          status_next = sti_pkg::ST_OK;
          ctl.rem     = accept;
        end
      end
      sti_pkg::CMD_FIND: begin
        if (stat.found) begin
          status_next = sti_pkg::ST_OK;
        end
      end
      default: begin
        status_next = sti_pkg::ST_MISSING;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CW'(1);
    end else if (ctl.rem) begin
      count_next = count - CW'(1);
    end
  end

  sti_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .value (s_tdata),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser     <= status_next;
      entry_count <= sti_pkg::COUNT_W'(count_next);
    end
  end

  assign m_tdata = {{(8 - sti_pkg::COUNT_W){1'b0}}, entry_count};

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_matches_count : assert property (@(posedge clk) disable iff (rst)
    stat.full == (count == CW'(CAPACITY)))
    else $error("last cell occupancy disagrees with count");

  a_find_keeps_count : assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == sti_pkg::CMD_FIND) |=> $stable(count))
    else $error("find changed the table");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> (m_tvalid && m_tdata[sti_pkg::COUNT_W-1:0] == sti_pkg::COUNT_W'(count)))
    else $error("result missing or count mismatch");

endmodule
